### hdl/bsp_pkg.sv
// bsp_pkg: shared constants, types and helpers for the blend skinning block.
// No dependencies; imported by every module of the block.
package bsp_pkg;

    localparam int MAX_BONES  = 64;
    localparam int INFLUENCES = 4;
    localparam int BONE_WORDS = 6;
    localparam int PICKS      = 4;   // bone/weight pairs carried by one item
    localparam int ROW_W      = $clog2(MAX_BONES);
    localparam int PICK_W     = $clog2(PICKS);
    localparam int WORD_SEL_W = $clog2(BONE_WORDS);
    localparam int SLOT_W     = 6;
    localparam int WEIGHT_W   = 16;
    localparam int KIND_W     = 3;
    localparam int ACC_W      = 51;  // four 49-bit products

    localparam logic [KIND_W-1:0] KIND_SKIN       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_FIRST = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOAD_LAST  = 3'd6;

    localparam logic [2:0] CFG_M00 = 3'd0;
    localparam logic [2:0] CFG_M01 = 3'd1;
    localparam logic [2:0] CFG_M10 = 3'd2;
    localparam logic [2:0] CFG_M11 = 3'd3;
    localparam logic [2:0] CFG_TX  = 3'd4;
    localparam logic [2:0] CFG_TY  = 3'd5;

    // matrix word positions: m00, m01, m10, m11, tx, ty
    localparam int W_M00 = 0;
    localparam int W_M01 = 1;
    localparam int W_M10 = 2;
    localparam int W_M11 = 3;
    localparam int W_TX  = 4;
    localparam int W_TY  = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLEND,
        ST_DRAIN,
        ST_MAT,
        ST_FIN,
        ST_SUM
    } bsp_state_t;

    typedef struct packed {
        logic clear;     // zero the accumulators
        logic use_bone;  // bone read issued this cycle contributes
        logic latch;     // capture the saturated blended matrix
    } bsp_blend_ctl_t;

    typedef logic signed [31:0] word_t;
    typedef word_t [BONE_WORDS-1:0] row_t;

    function automatic word_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

### hdl/bsp_if.sv
// bsp_if: valid/ready channel interfaces for items, results and config.
// Depends on bsp_pkg.
interface bsp_item_if
    import bsp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic signed [31:0]  coord_x;
    logic signed [31:0]  coord_y;
    logic [SLOT_W-1:0]   bone_a;
    logic [SLOT_W-1:0]   bone_b;
    logic [SLOT_W-1:0]   bone_c;
    logic [SLOT_W-1:0]   bone_d;
    logic [WEIGHT_W-1:0] weight_a;
    logic [WEIGHT_W-1:0] weight_b;
    logic [WEIGHT_W-1:0] weight_c;
    logic [WEIGHT_W-1:0] weight_d;
    logic signed [31:0]  table_word;

    modport source (output valid, kind, coord_x, coord_y, bone_a, bone_b, bone_c, bone_d,
                    weight_a, weight_b, weight_c, weight_d, table_word, input ready);
    modport sink (input valid, kind, coord_x, coord_y, bone_a, bone_b, bone_c, bone_d,
                  weight_a, weight_b, weight_c, weight_d, table_word, output ready);
endinterface

interface bsp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;

    modport source (output valid, skinned_x, skinned_y, input ready);
    modport sink (input valid, skinned_x, skinned_y, output ready);
endinterface

interface bsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hdl/bsp_bone_mem.sv
// bsp_bone_mem: bone table, one six-word row per bone, word write enables,
// registered read of a whole row. Depends on bsp_pkg.
module bsp_bone_mem
    import bsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [ROW_W-1:0]      waddr,
    input  logic [WORD_SEL_W-1:0] wsel,
    input  word_t                 wdata,
    input  logic [ROW_W-1:0]      raddr,
    output row_t                  rdata
);

    row_t mem [MAX_BONES];
    row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr][wsel] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bsp_mul4.sv
// bsp_mul4: four registered 32x32 signed multipliers, shared between the
// world transform and the final transform. Depends on bsp_pkg.
module bsp_mul4
    import bsp_pkg::*;
(
    input  logic               clk,
    input  word_t              a [4],
    input  word_t              b [4],
    output logic signed [63:0] p [4]
);

    logic signed [63:0] p_reg [4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            p_reg[i] <= a[i] * b[i];
    end

    assign p = p_reg;

endmodule

### hdl/bsp_blend.sv
// bsp_blend: six multiply-accumulate lanes that sum weighted bone rows,
// then saturate to the Q16.16 blended matrix. Depends on bsp_pkg.
module bsp_blend
    import bsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  bsp_blend_ctl_t      ctl,
    input  logic [WEIGHT_W-1:0] weight,
    input  row_t                rdata,
    output row_t                mat
);

    logic                    use1_reg;
    logic                    use2_reg;
    logic [WEIGHT_W-1:0]     w1_reg;
    logic signed [48:0]      prod_reg [BONE_WORDS];
    logic signed [ACC_W-1:0] acc_reg [BONE_WORDS];
    row_t                    mat_reg;
    logic signed [WEIGHT_W:0] w_ext;

    assign w_ext = {1'b0, w1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use1_reg <= 1'b0;
            use2_reg <= 1'b0;
        end
        else
        begin
            use1_reg <= ctl.use_bone;
            use2_reg <= use1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        w1_reg <= weight;
        for (int j = 0; j < BONE_WORDS; j++)
        begin
            prod_reg[j] <= rdata[j] * w_ext;
            if (ctl.clear)
                acc_reg[j] <= '0;
            else if (use2_reg)
                acc_reg[j] <= acc_reg[j] + ACC_W'(prod_reg[j]);
            if (ctl.latch)
                mat_reg[j] <= sat32(64'(acc_reg[j] >>> 15));
        end
    end

    assign mat = mat_reg;

endmodule

### hdl/blend_skin_point_2d_top.sv
// blend_skin_point_2d_top: 2D linear blend skinning with four bone influences.
// Depends on bsp_pkg, bsp_if, bsp_bone_mem, bsp_mul4 and bsp_blend.
//
// Usage
//   cfg    : world matrix writes (index 0..5 = m00, m01, m10, m11, tx, ty).
//            Always ready; an index above 5 is dropped.
//   item   : kind 1..6 loads word kind-1 of bone bone_a; no result.
//            kind 0 skins (coord_x, coord_y); kind 7 is dropped.
//   result : one skinned point per skin item, saturated Q16.16.
// Timing
//   A skin item holds the block after its transfer until its result is loaded: four bone
//   rows are read from the table one per cycle (one read port, one row per
//   bone), the multiply-accumulate pipe drains, then one step saturates
//   the blended matrix, one multiplies, one sums. The result is
//   shown the cycle after that. No new item is taken until a skin item is
//   through; load items are taken back to back.
// Reset
//   The world matrix returns to identity; the bone table is not cleared and
//   a bone must be loaded before a point uses it.
// Back-pressure
//   The result sits in an output register; the next item is taken while it
//   waits. A skin item that finishes while that register is still full holds
//   in its last step until the receiver takes the earlier result.
module blend_skin_point_2d_top
    import bsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    bsp_cfg_if.sink             cfg,
    bsp_item_if.sink            item,
    bsp_result_if.source        result
);

    bsp_state_t state_reg, state_next;
    logic [PICK_W-1:0] cnt_reg, cnt_next;

    word_t               world_reg [BONE_WORDS];
    logic signed [31:0]  x_reg, y_reg, px_reg, py_reg;
    logic [SLOT_W-1:0]   bone_reg   [PICKS];
    logic [WEIGHT_W-1:0] weight_reg [PICKS];

    logic  out_valid_reg;
    word_t out_x_reg, out_y_reg;

    // control from the output decode
    logic           take_item;
    logic           mul_final;     // multipliers work on the blended matrix
    logic           load_world_pt; // capture world-space point
    logic           load_out;
    bsp_blend_ctl_t blend_ctl;

    logic                  item_xfer;
    logic                  is_skin, is_load;
    logic                  mem_we;
    logic [ROW_W-1:0]      raddr;
    logic [SLOT_W-1:0]     cur_slot;
    logic [WEIGHT_W-1:0]   cur_weight;
    logic                  cur_use;
    row_t                  rdata, mat;
    word_t                 mul_a [4];
    word_t                 mul_b [4];
    logic signed [63:0]    mul_p [4];
    word_t                 sum0, sum1;
    word_t                 base0, base1;

    assign item_xfer = item.valid && item.ready;
    assign is_skin   = (item.kind == KIND_SKIN);
    assign is_load   = (item.kind >= KIND_LOAD_FIRST) && (item.kind <= KIND_LOAD_LAST);
    assign mem_we    = item_xfer && is_load && (int'(item.bone_a) < MAX_BONES);

    assign cur_slot   = bone_reg[cnt_reg];
    assign cur_weight = weight_reg[cnt_reg];
    assign cur_use    = (int'(cnt_reg) < INFLUENCES) && (cur_weight != '0)
                        && (int'(cur_slot) < MAX_BONES);
    assign raddr      = ROW_W'(cur_slot);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (item_xfer && is_skin)
                    state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PICK_W'(PICKS - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // cnt wrapped to 0 on entry
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PICK_W'(1))
                    state_next = ST_MAT;
            end
            ST_MAT:   state_next = ST_FIN;
            ST_FIN:   state_next = ST_SUM;
            ST_SUM:
            begin
                if (!out_valid_reg || result.ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb
    begin
        take_item          = 1'b0;
        mul_final          = 1'b0;
        load_world_pt      = 1'b0;
        load_out           = 1'b0;
        blend_ctl.clear    = 1'b0;
        blend_ctl.use_bone = 1'b0;
        blend_ctl.latch    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                take_item       = 1'b1;
                blend_ctl.clear = 1'b1;
            end
            ST_BLEND:
            begin
                blend_ctl.use_bone = cur_use;
                // world products land at the end of the first read cycle
                load_world_pt      = (cnt_reg == PICK_W'(1));
            end
            ST_DRAIN: ;
            ST_MAT:   blend_ctl.latch = 1'b1;
            ST_FIN:   mul_final = 1'b1;
            ST_SUM:
            begin
                // keep the final products on the multipliers while waiting
                mul_final = 1'b1;
                load_out  = !out_valid_reg || result.ready;
            end
            default: ;
        endcase
    end

    assign item.ready = take_item;
    assign cfg.ready  = 1'b1;

    // multiplier operands: world matrix with item point, or blended matrix
    // with world-space point
    always_comb
    begin
        if (mul_final)
        begin
            mul_a[0] = mat[W_M00]; mul_b[0] = px_reg;
            mul_a[1] = mat[W_M10]; mul_b[1] = py_reg;
            mul_a[2] = mat[W_M01]; mul_b[2] = px_reg;
            mul_a[3] = mat[W_M11]; mul_b[3] = py_reg;
            base0    = mat[W_TX];
            base1    = mat[W_TY];
        end
        else
        begin
            mul_a[0] = world_reg[W_M00]; mul_b[0] = x_reg;
            mul_a[1] = world_reg[W_M10]; mul_b[1] = y_reg;
            mul_a[2] = world_reg[W_M01]; mul_b[2] = x_reg;
            mul_a[3] = world_reg[W_M11]; mul_b[3] = y_reg;
            base0    = world_reg[W_TX];
            base1    = world_reg[W_TY];
        end
    end

    // floor-shifted products plus translation, saturated
    assign sum0 = sat32((mul_p[0] >>> 16) + (mul_p[1] >>> 16) + 64'(base0));
    assign sum1 = sat32((mul_p[2] >>> 16) + (mul_p[3] >>> 16) + 64'(base1));

    // final sums: blended products plus the blended translation
    word_t fin0, fin1;
    assign fin0 = sat32((mul_p[0] >>> 16) + (mul_p[1] >>> 16) + 64'(mat[W_TX]));
    assign fin1 = sat32((mul_p[2] >>> 16) + (mul_p[3] >>> 16) + 64'(mat[W_TY]));

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
            world_reg[W_M00] <= 32'sd65536;
            world_reg[W_M01] <= '0;
            world_reg[W_M10] <= '0;
            world_reg[W_M11] <= 32'sd65536;
            world_reg[W_TX]  <= '0;
            world_reg[W_TY]  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_M00: world_reg[W_M00] <= cfg.data;
                    CFG_M01: world_reg[W_M01] <= cfg.data;
                    CFG_M10: world_reg[W_M10] <= cfg.data;
                    CFG_M11: world_reg[W_M11] <= cfg.data;
                    CFG_TX:  world_reg[W_TX]  <= cfg.data;
                    CFG_TY:  world_reg[W_TY]  <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer && is_skin)
        begin
            x_reg         <= item.coord_x;
            y_reg         <= item.coord_y;
            bone_reg[0]   <= item.bone_a;
            bone_reg[1]   <= item.bone_b;
            bone_reg[2]   <= item.bone_c;
            bone_reg[3]   <= item.bone_d;
            weight_reg[0] <= item.weight_a;
            weight_reg[1] <= item.weight_b;
            weight_reg[2] <= item.weight_c;
            weight_reg[3] <= item.weight_d;
        end
        if (load_world_pt)
        begin
            px_reg <= sum0;
            py_reg <= sum1;
        end
        if (load_out)
        begin
            out_x_reg <= fin0;
            out_y_reg <= fin1;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.skinned_x = out_x_reg;
    assign result.skinned_y = out_y_reg;

    // ---------------- datapath units ----------------
    bsp_bone_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ROW_W'(item.bone_a)),
        .wsel  (WORD_SEL_W'(item.kind - KIND_LOAD_FIRST)),
        .wdata (item.table_word),
        .raddr (raddr),
        .rdata (rdata)
    );

    bsp_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (blend_ctl),
        .weight (cur_weight),
        .rdata  (rdata),
        .mat    (mat)
    );

    bsp_mul4 u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

endmodule

### tb/tb.sv
// tb: self-checking bench for blend_skin_point_2d_top (2D blend skinning).
// Depends on bsp_pkg, the bsp_if channel interfaces and the block's RTL.
module tb;
    import bsp_pkg::*;

    localparam int  HALF      = 4;
    localparam int  SETTLE    = 16;      // settle time after the last expected result
    localparam int  LIMIT     = 400000;
    localparam int  HOLD_LEN  = 400;
    localparam int  PHASE_LEN = 165;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic signed [31:0]  cx;
        logic signed [31:0]  cy;
        logic [SLOT_W-1:0]   slot [PICKS];
        logic [WEIGHT_W-1:0] wt [PICKS];
        logic signed [31:0]  word;
        bit                  typed;     // expectation typed in by hand
        logic signed [31:0]  tx_exp;
        logic signed [31:0]  ty_exp;
    } item_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bsp_cfg_if    cfg_ch ();
    bsp_item_if   item_ch ();
    bsp_result_if res_ch ();

    blend_skin_point_2d_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .item   (item_ch.sink),
        .result (res_ch.source)
    );

    always #HALF clk = ~clk;

    // predictor state: world matrix and bone table, kept at transfer time
    longint world_m [BONE_WORDS];
    longint bone_mem [MAX_BONES][BONE_WORDS];
    bit     loaded [MAX_BONES][BONE_WORDS];   // generator's view of written words

    point_t skinned_q [$];
    int     errors = 0;
    int     cycles = 0;
    int     n_skin = 0, n_load = 0, n_drop = 0, n_phase = 0, n_seen = 0;
    bit     hold_req = 1'b0;
    bit     cur_typed = 1'b0;
    logic signed [31:0] cur_ex, cur_ey;
    int     burst_left = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    // world transform, blend of the weighted bones, then the blended transform
    function automatic point_t skin_point(item_t it);
        longint px, py, blended [BONE_WORDS], acc [BONE_WORDS];
        longint s, w;
        point_t r;
        for (int j = 0; j < BONE_WORDS; j++)
            acc[j] = 0;
        px = clamp32(fx_mul(world_m[W_M00], it.cx) + fx_mul(world_m[W_M10], it.cy)
                     + world_m[W_TX]);
        py = clamp32(fx_mul(world_m[W_M01], it.cx) + fx_mul(world_m[W_M11], it.cy)
                     + world_m[W_TY]);
        for (int i = 0; i < INFLUENCES; i++) begin
            s = it.slot[i];
            w = it.wt[i];
            if (w == 0 || s >= MAX_BONES)
                continue;
            for (int j = 0; j < BONE_WORDS; j++)
                acc[j] += bone_mem[s][j] * w;
        end
        for (int j = 0; j < BONE_WORDS; j++)
            blended[j] = clamp32(acc[j] >>> 15);
        r.x = clamp32(fx_mul(blended[W_M00], px) + fx_mul(blended[W_M10], py)
                      + blended[W_TX]);
        r.y = clamp32(fx_mul(blended[W_M01], px) + fx_mul(blended[W_M11], py)
                      + blended[W_TY]);
        return r;
    endfunction

    task automatic report(string msg);
        $display("MISMATCH %s (t=%0t)", msg, $time);
        errors++;
    endtask

    // ---------------- monitors ----------------
    // config transfers update the predicted world matrix
    always @(posedge clk)
        if (rst_n && cfg_ch.valid && cfg_ch.ready && cfg_ch.index < BONE_WORDS)
            world_m[cfg_ch.index] = longint'(signed'(cfg_ch.data));

    // item transfers: loads update the table, skins queue an expected point
    always @(posedge clk) begin
        item_t  it;
        point_t p;
        if (rst_n && item_ch.valid && item_ch.ready) begin
            it.kind = item_ch.kind;
            it.cx = item_ch.coord_x;
            it.cy = item_ch.coord_y;
            it.slot[0] = item_ch.bone_a; it.wt[0] = item_ch.weight_a;
            it.slot[1] = item_ch.bone_b; it.wt[1] = item_ch.weight_b;
            it.slot[2] = item_ch.bone_c; it.wt[2] = item_ch.weight_c;
            it.slot[3] = item_ch.bone_d; it.wt[3] = item_ch.weight_d;
            if (it.kind >= KIND_LOAD_FIRST && it.kind <= KIND_LOAD_LAST) begin
                if (it.slot[0] < MAX_BONES)
                    bone_mem[it.slot[0]][it.kind - KIND_LOAD_FIRST] =
                        longint'(item_ch.table_word);
                n_load++;
            end else if (it.kind == KIND_SKIN) begin
                if (cur_typed) begin
                    p.x = cur_ex;
                    p.y = cur_ey;
                end else
                    p = skin_point(it);
                skinned_q.push_back(p);
                n_skin++;
            end else
                n_drop++;
        end
    end

    // result transfers checked against the oldest expectation
    always @(posedge clk) begin
        point_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            n_seen++;
            if (skinned_q.size() == 0) begin
                report($sformatf("unexpected result x=%0d y=%0d",
                                 res_ch.skinned_x, res_ch.skinned_y));
            end else begin
                want = skinned_q.pop_front();
                if (res_ch.skinned_x !== want.x)
                    report($sformatf("skinned_x: got %0d expected %0d",
                                     res_ch.skinned_x, want.x));
                if (res_ch.skinned_y !== want.y)
                    report($sformatf("skinned_y: got %0d expected %0d",
                                     res_ch.skinned_y, want.y));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, skinned_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- receiver ----------------
    // stall pattern redrawn at random from three modes; a long hold-off on request
    initial begin
        int mode;
        int tick;
        res_ch.ready <= 1'b0;
        tick = 0;
        mode = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                if (tick % 64 == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 9) < 7);
                    default: res_ch.ready <= (tick % 5 >= 2);
                endcase
                tick++;
                @(posedge clk);
            end
        end
    end

    // ---------------- sender side ----------------
    task automatic send_item(item_t it);
        item_ch.valid      <= 1'b1;
        item_ch.kind       <= it.kind;
        item_ch.coord_x    <= it.cx;
        item_ch.coord_y    <= it.cy;
        item_ch.bone_a     <= it.slot[0];
        item_ch.bone_b     <= it.slot[1];
        item_ch.bone_c     <= it.slot[2];
        item_ch.bone_d     <= it.slot[3];
        item_ch.weight_a   <= it.wt[0];
        item_ch.weight_b   <= it.wt[1];
        item_ch.weight_c   <= it.wt[2];
        item_ch.weight_d   <= it.wt[3];
        item_ch.table_word <= it.word;
        cur_typed          <= it.typed;
        cur_ex             <= it.tx_exp;
        cur_ey             <= it.ty_exp;
        if (it.kind >= KIND_LOAD_FIRST && it.kind <= KIND_LOAD_LAST)
            loaded[it.slot[0]][it.kind - KIND_LOAD_FIRST] = 1'b1;
        do
            @(posedge clk);
        while (!item_ch.ready);
        // bursts of random length, with a gap after each
        if (burst_left == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end else
            burst_left--;
    endtask

    task automatic write_world(logic [2:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    // wait for the block to drain before touching the world matrix
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (skinned_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_world(logic [31:0] m00, logic [31:0] m01, logic [31:0] m10,
                             logic [31:0] m11, logic [31:0] tx, logic [31:0] ty);
        write_world(CFG_M00, m00);
        write_world(CFG_M01, m01);
        write_world(CFG_M10, m10);
        write_world(CFG_M11, m11);
        write_world(CFG_TX, tx);
        write_world(CFG_TY, ty);
        cfg_ch.valid <= 1'b0;
        n_phase++;
    endtask

    function automatic logic signed [31:0] pick_word(bit wide);
        if (wide || $urandom_range(0, 4) == 0)
            return $urandom;
        return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endfunction

    function automatic bit bone_usable(int s);
        for (int j = 0; j < BONE_WORDS; j++)
            if (!loaded[s][j])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] usable_slot();
        int s;
        s = $urandom_range(0, MAX_BONES - 1);
        while (!bone_usable(s))
            s = (s + 1) % MAX_BONES;
        return SLOT_W'(s);
    endfunction

    function automatic item_t blank_item();
        item_t it;
        it.kind = KIND_SKIN;
        it.cx = 0;
        it.cy = 0;
        for (int i = 0; i < PICKS; i++) begin
            it.slot[i] = '0;
            it.wt[i] = '0;
        end
        it.word = 0;
        it.typed = 1'b0;
        it.tx_exp = 0;
        it.ty_exp = 0;
        return it;
    endfunction

    function automatic item_t load_item(int s, int w, logic signed [31:0] v);
        item_t it;
        it = blank_item();
        it.kind = KIND_LOAD_FIRST + KIND_W'(w);
        it.slot[0] = SLOT_W'(s);
        it.word = v;
        for (int i = 1; i < PICKS; i++)
            it.slot[i] = SLOT_W'($urandom);
        return it;
    endfunction

    function automatic item_t rand_skin(bit wide);
        item_t it;
        int    left;
        int    mode;
        it = blank_item();
        it.cx = wide ? $urandom : $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        it.cy = wide ? $urandom : $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        mode = $urandom_range(0, 9);
        left = 32768;
        for (int i = 0; i < PICKS; i++) begin
            it.slot[i] = usable_slot();
            if (mode < 6) begin
                // weights that sum to one
                it.wt[i] = WEIGHT_W'((i == PICKS - 1) ? left : $urandom_range(0, left));
                left -= it.wt[i];
            end else if (mode < 8)
                it.wt[i] = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
            else
                it.wt[i] = 16'($urandom);
        end
        return it;
    endfunction

    // full bone loads mostly, the odd lone word otherwise
    task automatic load_bone(bit wide, output int n);
        int s;
        s = $urandom_range(0, MAX_BONES - 1);
        if ($urandom_range(0, 4) == 0) begin
            send_item(load_item(s, $urandom_range(0, BONE_WORDS - 1), pick_word(wide)));
            n = 1;
        end else begin
            for (int w = 0; w < BONE_WORDS; w++)
                send_item(load_item(s, w,
                    (w == W_M00 || w == W_M11) && !wide && $urandom_range(0, 1)
                    ? 32'sd65536 + pick_word(1'b0) / 4 : pick_word(wide)));
            n = BONE_WORDS;
        end
    endtask

    task automatic random_phase(int count, bit wide, bit with_hold);
        int sent;
        int r;
        int n;
        bit held;
        item_t it;
        sent = 0;
        held = 1'b0;
        while (sent < count) begin
            if (with_hold && !held && sent >= count / 3) begin
                hold_req = 1'b1;    // receiver stops; input should back up
                held = 1'b1;
            end
            r = $urandom_range(0, 19);
            if (r < 6) begin
                load_bone(wide, n);
                sent += n;
            end else if (r == 6) begin
                it = rand_skin(wide);
                it.kind = KIND_UNUSED;   // dropped by the block
                send_item(it);
                sent++;
            end else begin
                send_item(rand_skin(wide || $urandom_range(0, 7) == 0));
                sent++;
            end
        end
    endtask

    // ---------------- directed table ----------------
    item_t directed [$];

    task automatic build_directed();
        item_t it;
        logic signed [31:0] ident [BONE_WORDS];
        logic signed [31:0] ext [BONE_WORDS];
        ident = '{32'sd65536, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0};
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        // identity bone in slot 0
        for (int w = 0; w < BONE_WORDS; w++)
            directed.push_back(load_item(0, w, ident[w]));
        // identity everywhere: point passes straight through
        it = blank_item();
        it.cx = 32'sd65536; it.cy = 32'sd131072;
        it.wt[0] = 16'd32768;
        it.typed = 1'b1; it.tx_exp = 32'sd65536; it.ty_exp = 32'sd131072;
        directed.push_back(it);
        // unused kind: no result
        it.kind = KIND_UNUSED; it.typed = 1'b0;
        directed.push_back(it);
        // no weights: blended matrix is zero
        it = blank_item();
        it.cx = 32'sh7fffffff; it.cy = 32'sh80000000;
        it.typed = 1'b1; it.tx_exp = 0; it.ty_exp = 0;
        directed.push_back(it);
        // extreme words in the top slot
        for (int w = 0; w < BONE_WORDS; w++)
            directed.push_back(load_item(MAX_BONES - 1, w, ext[w]));
        // extreme coordinates, weights above one, saturation
        it = blank_item();
        it.cx = 32'sh7fffffff; it.cy = 32'sh7fffffff;
        for (int i = 0; i < PICKS; i++) begin
            it.slot[i] = SLOT_W'(MAX_BONES - 1);
            it.wt[i] = 16'hffff;
        end
        directed.push_back(it);
        it.cx = 32'sh80000000; it.cy = 32'sh80000000;
        for (int i = 0; i < PICKS; i++)
            it.wt[i] = 16'd32768;
        directed.push_back(it);
        // mixed: identity bone twice, one extreme bone at zero weight, one at the lowest nonzero weight
        it.cx = 32'sh00018000; it.cy = -32'sh00020000;
        it.slot[0] = '0; it.wt[0] = 16'd16384;
        it.slot[1] = SLOT_W'(MAX_BONES - 1); it.wt[1] = 16'd0;
        it.slot[2] = '0; it.wt[2] = 16'd16384;
        it.slot[3] = SLOT_W'(MAX_BONES - 1); it.wt[3] = 16'd1;
        directed.push_back(it);
    endtask

    // ---------------- main sequence ----------------
    initial begin
        for (int s = 0; s < MAX_BONES; s++)
            for (int j = 0; j < BONE_WORDS; j++) begin
                loaded[s][j] = 1'b0;
                bone_mem[s][j] = 0;
            end
        world_m = '{65536, 0, 0, 65536, 0, 0};
        cfg_ch.valid <= 1'b0; cfg_ch.index <= '0; cfg_ch.data <= '0;
        item_ch.valid <= 1'b0; item_ch.kind <= '0;
        item_ch.coord_x <= '0; item_ch.coord_y <= '0;
        item_ch.bone_a <= '0; item_ch.bone_b <= '0;
        item_ch.bone_c <= '0; item_ch.bone_d <= '0;
        item_ch.weight_a <= '0; item_ch.weight_b <= '0;
        item_ch.weight_c <= '0; item_ch.weight_d <= '0;
        item_ch.table_word <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset world matrix
        build_directed();
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        // random part across several world settings, extremes included
        set_world(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        random_phase(PHASE_LEN, 1'b0, 1'b1);
        drain();
        set_world(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 32'h80000000);
        random_phase(PHASE_LEN, 1'b1, 1'b0);
        drain();
        set_world($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(PHASE_LEN, 1'b1, 1'b0);
        drain();
        set_world(32'h00010000 + $urandom_range(0, 'hffff), $urandom_range(0, 'h3fff),
                  -$urandom_range(0, 'h3fff), 32'h0000c000,
                  $urandom_range(0, 'hfffff), -$urandom_range(0, 'hfffff));
        random_phase(PHASE_LEN, 1'b0, 1'b0);
        drain();
        set_world(32'h00010000, 0, 0, 32'h00010000, 32'h00050000, 32'hfffd0000);
        random_phase(PHASE_LEN, 1'b0, 1'b0);
        drain();

        if (skinned_q.size() != 0)
            report($sformatf("%0d expected results never arrived", skinned_q.size()));
        $display("covered %0d skin, %0d load and %0d dropped items over %0d world settings",
                 n_skin, n_load, n_drop, n_phase + 1);
        $display("%0d results checked, %0d mismatches", n_seen, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
hdl/bsp_pkg.sv
hdl/bsp_if.sv
hdl/bsp_bone_mem.sv
hdl/bsp_mul4.sv
hdl/bsp_blend.sv
hdl/blend_skin_point_2d_top.sv
tb/tb.sv
